### sv/ltx_pkg.sv
// shared types and constants for the length/type xor frame builder
// used by ltx_front, ltx_back and the top level, depends on nothing

package ltx_pkg;

	localparam int LTX_LENGTH_BITS = 16;
	localparam int LTX_CMD_DEPTH   = 4;
	localparam int LTX_OUT_DEPTH   = 4;

	localparam logic KIND_START   = 1'b0;
	localparam logic KIND_PAYLOAD = 1'b1;

	localparam logic [1:0] CFG_HEADER_FIRST  = 2'd0;
	localparam logic [1:0] CFG_HEADER_SECOND = 2'd1;
	localparam logic [1:0] CFG_TAIL_FIRST    = 2'd2;
	localparam logic [1:0] CFG_TAIL_SECOND   = 2'd3;

	localparam logic [1:0] ERR_NONE   = 2'd0;
	localparam logic [1:0] ERR_STRAY  = 2'd1;
	localparam logic [1:0] ERR_OPEN   = 2'd2;
	localparam logic [1:0] ERR_LENGTH = 2'd3;

	typedef enum logic [3:0] {
		STEP_HDR_FIRST,
		STEP_HDR_SECOND,
		STEP_LEN_LO,
		STEP_LEN_HI,
		STEP_BODY,
		STEP_CHK_LO,
		STEP_CHK_HI,
		STEP_TAIL_FIRST,
		STEP_TAIL_SECOND
	} step_t;

	typedef enum logic [1:0] {
		OP_ERROR,
		OP_START,
		OP_DATA
	} cmd_op_t;

	typedef struct packed {
		logic        kind;
		logic [7:0]  frame_type;
		logic [15:0] payload_length;
		logic [7:0]  data_byte;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       frame_end;
		logic [1:0] error_code;
	} out_item_t;

	typedef struct packed {
		cmd_op_t    op;
		logic [1:0] err;
		logic       last;
		logic [7:0] val;
		logic [7:0] len_lo;
		logic [7:0] len_hi;
		logic [7:0] chk;
	} cmd_t;

endpackage

### sv/ltx_fifo.sv
// small first-in first-out register queue with registered occupancy
// used for the command queue and the output queue, no package needed

module ltx_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) count_q <= CW'(DEPTH))
		else $error("queue occupancy beyond depth");

	assert property (@(posedge clk) disable iff (!arst_n)
		(do_push && !do_pop) |=> !empty)
		else $error("queue empty after a lone write");

endmodule

### sv/ltx_front.sv
// front end: accepts items, tracks the open frame and classifies each item
// into one command for the back end, uses ltx_pkg

module ltx_front import ltx_pkg::*; #(
	parameter int LENGTH_BITS = LTX_LENGTH_BITS
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     accept,
	input  in_item_t item,
	output cmd_t     cmd
);

	localparam logic [16:0] MAX_LEN = 17'((1 << LENGTH_BITS) - 10);

	logic                   open_q;
	logic [LENGTH_BITS-1:0] remaining_q;
	logic [7:0]             xor_q;
	logic [LENGTH_BITS-1:0] rem_next;
	logic [7:0]             data_xor;
	logic [7:0]             hdr_xor;
	logic                   too_long;

	assign rem_next = remaining_q - 1'b1;
	assign data_xor = xor_q ^ item.data_byte;
	assign hdr_xor  = item.payload_length[7:0] ^ item.payload_length[15:8] ^ item.frame_type;
	assign too_long = ({1'b0, item.payload_length} > MAX_LEN);

	always_comb begin
		cmd        = '0;
		cmd.op     = OP_ERROR;
		cmd.err    = ERR_NONE;
		cmd.len_lo = item.payload_length[7:0];
		cmd.len_hi = item.payload_length[15:8];
		if (item.kind == KIND_PAYLOAD) begin
			if (!open_q) begin
				cmd.err = ERR_STRAY;
			end else begin
				cmd.op   = OP_DATA;
				cmd.val  = item.data_byte;
				cmd.chk  = data_xor;
				cmd.last = (rem_next == '0);
			end
		end else if (open_q) begin
			cmd.err = ERR_OPEN;
		end else if (too_long) begin
			cmd.err = ERR_LENGTH;
		end else begin
			cmd.op   = OP_START;
			cmd.val  = item.frame_type;
			cmd.chk  = hdr_xor;
			cmd.last = (item.payload_length == '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q      <= 1'b0;
			remaining_q <= '0;
			xor_q       <= '0;
		end else if (accept) begin
			if (cmd.op == OP_DATA) begin
				xor_q       <= data_xor;
				remaining_q <= rem_next;
				open_q      <= (rem_next != '0);
			end else if (cmd.op == OP_START) begin
				xor_q       <= hdr_xor;
				remaining_q <= item.payload_length[LENGTH_BITS-1:0];
				open_q      <= (item.payload_length != '0);
			end
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) open_q == (remaining_q != '0))
		else $error("open frame and remaining count disagree");

endmodule

### sv/ltx_back.sv
// back end: holds the header and tail registers and expands each command
// into output beats, one per cycle while the output queue has room, uses ltx_pkg

module ltx_back import ltx_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [1:0] cfg_index,
	input  logic [7:0] cfg_data,
	input  cmd_t       cmd,
	input  logic       cmd_valid,
	output logic       cmd_pop,
	output out_item_t  beat,
	output logic       beat_push,
	input  logic       beat_full
);

	logic [7:0] hdr_first_q;
	logic [7:0] hdr_second_q;
	logic [7:0] tail_first_q;
	logic [7:0] tail_second_q;
	logic       busy_q;
	step_t      step_q;
	step_t      step;
	logic       busy_d;
	step_t      step_d;
	logic       done;
	logic       fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr_first_q   <= '0;
			hdr_second_q  <= '0;
			tail_first_q  <= '0;
			tail_second_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_HEADER_FIRST:  hdr_first_q   <= cfg_data;
				CFG_HEADER_SECOND: hdr_second_q  <= cfg_data;
				CFG_TAIL_FIRST:    tail_first_q  <= cfg_data;
				CFG_TAIL_SECOND:   tail_second_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		if (busy_q) begin
			step = step_q;
		end else if (cmd.op == OP_DATA) begin
			step = STEP_BODY;
		end else begin
			step = STEP_HDR_FIRST;
		end
	end

	assign done = (cmd.op == OP_ERROR) || (step == STEP_TAIL_SECOND)
		|| ((step == STEP_BODY) && !cmd.last);
	assign fire      = cmd_valid && !beat_full;
	assign beat_push = fire;
	assign cmd_pop   = fire && done;

	always_comb begin
		busy_d = busy_q;
		step_d = step_q;
		if (fire) begin
			busy_d = !done;
			step_d = done ? STEP_HDR_FIRST : step_t'(step + 4'd1);
		end
	end

	always_comb begin
		beat            = '0;
		beat.error_code = ERR_NONE;
		if (cmd.op == OP_ERROR) begin
			beat.error_code = cmd.err;
		end else begin
			case (step)
				STEP_HDR_FIRST:   beat.out_byte = hdr_first_q;
				STEP_HDR_SECOND:  beat.out_byte = hdr_second_q;
				STEP_LEN_LO:      beat.out_byte = cmd.len_lo;
				STEP_LEN_HI:      beat.out_byte = cmd.len_hi;
				STEP_BODY:        beat.out_byte = cmd.val;
				STEP_CHK_LO:      beat.out_byte = cmd.chk;
				STEP_CHK_HI:      beat.out_byte = '0;
				STEP_TAIL_FIRST:  beat.out_byte = tail_first_q;
				STEP_TAIL_SECOND: begin
					beat.out_byte  = tail_second_q;
					beat.frame_end = 1'b1;
				end
				default:          beat.out_byte = '0;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= STEP_HDR_FIRST;
		end else begin
			busy_q <= busy_d;
			step_q <= step_d;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) busy_q |-> cmd_valid)
		else $error("command left the queue mid expansion");

	assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (step_q != STEP_HDR_FIRST) && (step_q <= STEP_TAIL_SECOND))
		else $error("beat step out of range");

endmodule

### sv/length_type_xor_frame_builder.sv
// top level of the length/type xor frame builder
// instantiates ltx_front, ltx_fifo (twice) and ltx_back, uses ltx_pkg
//
// input side is a queue: an item is taken when push is high and full is low.
// a start item opens a frame and yields five beats (two header bytes, the
// length low byte first, the type); each payload item yields its byte; the
// last payload byte, or a start with zero length, adds the checksum low and
// high bytes and the two tail bytes, frame_end marking the final one.
// errors give one beat with out_byte zero and the error code.
// result side is a queue too: the oldest beat sits on result while empty is
// low and leaves when pop is high.
// one item is taken per cycle while the command queue has room; the back end
// writes one beat per cycle into the output queue while it has room, so a
// payload stream keeps a rate of one byte per cycle; header and tail bursts
// fill the queues. with both queues empty the first beat of an item goes
// through the command queue, then the output queue, before it is on result.
// when the receiver stalls, the output queue fills, the back end holds, the
// command queue fills and full rises. reset clears both queues, the open
// frame and the four byte registers. the user writes those registers through
// wr_en, wr_index and wr_data only while idle; the block never enforces it.

module length_type_xor_frame_builder import ltx_pkg::*; #(
	parameter int LENGTH_BITS = LTX_LENGTH_BITS,
	parameter int CMD_DEPTH   = LTX_CMD_DEPTH,
	parameter int OUT_DEPTH   = LTX_OUT_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       wr_en,
	input  logic [1:0] wr_index,
	input  logic [7:0] wr_data,
	input  in_item_t   item,
	input  logic       push,
	output logic       full,
	output out_item_t  result,
	output logic       empty,
	input  logic       pop
);

	logic      accept;
	cmd_t      new_cmd;
	cmd_t      head_cmd;
	logic      cmd_empty;
	logic      cmd_pop;
	out_item_t beat;
	logic      beat_push;
	logic      beat_full;

	assign accept = push && !full;

	ltx_front #(
		.LENGTH_BITS(LENGTH_BITS)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.item   (item),
		.cmd    (new_cmd)
	);

	ltx_fifo #(
		.WIDTH($bits(cmd_t)),
		.DEPTH(CMD_DEPTH)
	) u_cmd_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (accept),
		.wdata  (new_cmd),
		.full   (full),
		.pop    (cmd_pop),
		.rdata  (head_cmd),
		.empty  (cmd_empty)
	);

	ltx_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (wr_en),
		.cfg_index (wr_index),
		.cfg_data  (wr_data),
		.cmd       (head_cmd),
		.cmd_valid (!cmd_empty),
		.cmd_pop   (cmd_pop),
		.beat      (beat),
		.beat_push (beat_push),
		.beat_full (beat_full)
	);

	ltx_fifo #(
		.WIDTH($bits(out_item_t)),
		.DEPTH(OUT_DEPTH)
	) u_out_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (beat_push),
		.wdata  (beat),
		.full   (beat_full),
		.pop    (pop),
		.rdata  (result),
		.empty  (empty)
	);

endmodule

### dv/tb.sv
// self-checking bench for length_type_xor_frame_builder: sends start and payload items,
// writes the four byte registers, predicts every output beat and checks them in order
// depends on ltx_pkg and the block's rtl only

module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import ltx_pkg::*;

	localparam int LONGEST_PAYLOAD = (1 << LTX_LENGTH_BITS) - 10;
	localparam int CYCLE_LIMIT     = 1_000_000;
	localparam int SETTLE_CYCLES   = 8;
	localparam int RANDOM_ITEMS    = 90;

	logic       clk      = 1'b0;
	logic       arst_n   = 1'b0;
	logic       wr_en    = 1'b0;
	logic [1:0] wr_index = CFG_HEADER_FIRST;
	logic [7:0] wr_data  = 8'h00;
	in_item_t   item     = '0;
	logic       push     = 1'b0;
	logic       full;
	out_item_t  result;
	logic       empty;
	logic       pop      = 1'b0;

	out_item_t   pending_beats [$];
	logic [7:0]  frame_cfg [4];
	logic        frame_is_open;
	logic [15:0] bytes_left;
	logic [7:0]  running_chk;

	bit          send_gaps_on   = 1'b1;
	bit          recv_stalls_on = 1'b1;
	int          hold_request   = 0;
	bit          saw_full       = 1'b0;
	int unsigned cycle_count    = 0;
	int unsigned fail_count     = 0;
	int unsigned items_sent     = 0;
	int unsigned beats_checked  = 0;
	int unsigned frames_closed  = 0;
	int unsigned error_beats    = 0;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	length_type_xor_frame_builder i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.item     (item),
		.push     (push),
		.full     (full),
		.result   (result),
		.empty    (empty),
		.pop      (pop)
	);

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (push && full) begin
			saw_full <= 1'b1;
		end
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("length_type_xor_frame_builder verification failed");
			$finish;
		end
	end

	// predictor
	function automatic void queue_beat(input logic [7:0] b, input logic is_last,
		input logic [1:0] err);
		out_item_t beat;
		beat.out_byte   = b;
		beat.frame_end  = is_last;
		beat.error_code = err;
		pending_beats.push_back(beat);
	endfunction

	function automatic void queue_trailer();
		queue_beat(running_chk, 1'b0, ERR_NONE);
		queue_beat(8'h00, 1'b0, ERR_NONE);
		queue_beat(frame_cfg[CFG_TAIL_FIRST], 1'b0, ERR_NONE);
		queue_beat(frame_cfg[CFG_TAIL_SECOND], 1'b1, ERR_NONE);
		frame_is_open = 1'b0;
		bytes_left    = '0;
	endfunction

	function automatic void predict_beats(input in_item_t it);
		if (it.kind == KIND_PAYLOAD) begin
			if (!frame_is_open) begin
				queue_beat(8'h00, 1'b0, ERR_STRAY);
			end else begin
				queue_beat(it.data_byte, 1'b0, ERR_NONE);
				running_chk = running_chk ^ it.data_byte;
				bytes_left  = bytes_left - 16'd1;
				if (bytes_left == 16'd0) begin
					queue_trailer();
				end
			end
		end else if (frame_is_open) begin
			queue_beat(8'h00, 1'b0, ERR_OPEN);
		end else if (it.payload_length > LONGEST_PAYLOAD) begin
			queue_beat(8'h00, 1'b0, ERR_LENGTH);
		end else begin
			queue_beat(frame_cfg[CFG_HEADER_FIRST], 1'b0, ERR_NONE);
			queue_beat(frame_cfg[CFG_HEADER_SECOND], 1'b0, ERR_NONE);
			queue_beat(it.payload_length[7:0], 1'b0, ERR_NONE);
			queue_beat(it.payload_length[15:8], 1'b0, ERR_NONE);
			queue_beat(it.frame_type, 1'b0, ERR_NONE);
			running_chk = it.payload_length[7:0] ^ it.payload_length[15:8] ^ it.frame_type;
			if (it.payload_length == 16'd0) begin
				queue_trailer();
			end else begin
				frame_is_open = 1'b1;
				bytes_left    = it.payload_length;
			end
		end
	endfunction

	// result side
	initial begin : beat_sink
		int stall;
		wait (arst_n === 1'b1);
		forever begin
			if (hold_request > 0) begin
				stall = hold_request;
				hold_request = 0;
			end else begin
				stall = recv_stalls_on ? $urandom_range(0, 11) : 0;
			end
			if (stall > 0) begin
				pop <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			pop <= 1'b1;
			do begin
				@(posedge clk);
			end while (empty);
		end
	end

	always @(posedge clk) begin
		out_item_t want;
		if (arst_n && pop && !empty) begin
			beats_checked++;
			if (pending_beats.size() == 0) begin
				$error("unexpected beat: out_byte %02h frame_end %0b error_code %0d",
					result.out_byte, result.frame_end, result.error_code);
				fail_count++;
			end else begin
				want = pending_beats.pop_front();
				if (result.out_byte !== want.out_byte) begin
					$error("out_byte: expected %02h, got %02h", want.out_byte, result.out_byte);
					fail_count++;
				end
				if (result.frame_end !== want.frame_end) begin
					$error("frame_end: expected %0b, got %0b", want.frame_end, result.frame_end);
					fail_count++;
				end
				if (result.error_code !== want.error_code) begin
					$error("error_code: expected %0d, got %0d", want.error_code,
						result.error_code);
					fail_count++;
				end
				if (want.frame_end) begin
					frames_closed++;
				end
				if (want.error_code != ERR_NONE) begin
					error_beats++;
				end
			end
		end
	end

	// input side
	function automatic in_item_t build_item(input logic kind, input logic [7:0] ftype,
		input logic [15:0] len, input logic [7:0] data);
		in_item_t it;
		it.kind           = kind;
		it.frame_type     = ftype;
		it.payload_length = len;
		it.data_byte      = data;
		return it;
	endfunction

	function automatic in_item_t make_item(input logic kind);
		return build_item(kind, 8'($urandom), 16'($urandom), 8'($urandom));
	endfunction

	function automatic int pick_length();
		return ($urandom_range(0, 99) < 75) ? $urandom_range(0, 8) : $urandom_range(9, 40);
	endfunction

	task automatic send_item(input in_item_t it);
		int gap;
		gap = send_gaps_on ? $urandom_range(0, 11) : 0;
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item <= it;
		push <= 1'b1;
		do begin
			@(posedge clk);
		end while (full);
		predict_beats(it);
		items_sent++;
	endtask

	task automatic send_frame(input int len, input bit mix_in_starts);
		in_item_t it;
		in_item_t extra;
		it = make_item(KIND_START);
		it.payload_length = 16'(len);
		send_item(it);
		if (len > LONGEST_PAYLOAD) begin
			return;
		end
		for (int n = 0; n < len; n++) begin
			if (mix_in_starts && $urandom_range(0, 7) == 0) begin
				extra = make_item(KIND_START);
				extra.payload_length = 16'(pick_length());
				send_item(extra);
			end
			send_item(make_item(KIND_PAYLOAD));
		end
	endtask

	task automatic settle();
		push <= 1'b0;
		while (pending_beats.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
		wr_en    <= 1'b1;
		wr_index <= idx;
		wr_data  <= val;
		@(posedge clk);
		frame_cfg[idx] = val;
	endtask

	task automatic load_frame_bytes(input logic [7:0] hdr_a, input logic [7:0] hdr_b,
		input logic [7:0] tail_a, input logic [7:0] tail_b);
		settle();
		write_reg(CFG_HEADER_FIRST, hdr_a);
		write_reg(CFG_HEADER_SECOND, hdr_b);
		write_reg(CFG_TAIL_FIRST, tail_a);
		write_reg(CFG_TAIL_SECOND, tail_b);
		wr_en <= 1'b0;
	endtask

	// tests
	task automatic test_reset_values();
		send_item(build_item(KIND_PAYLOAD, 8'h00, 16'h0000, 8'h5A));
		send_item(build_item(KIND_START, 8'hA5, 16'h0000, 8'h00));
		settle();
	endtask

	task automatic test_special_cases();
		load_frame_bytes(8'hFF, 8'hFF, 8'hFF, 8'hFF);
		send_item(build_item(KIND_PAYLOAD, 8'hFF, 16'hFFFF, 8'hFF));
		send_item(build_item(KIND_START, 8'hFF, 16'h0000, 8'hFF));
		send_item(build_item(KIND_START, 8'h00, 16'h0001, 8'h00));
		send_item(build_item(KIND_PAYLOAD, 8'h00, 16'h0000, 8'h00));
		send_item(build_item(KIND_START, 8'h3C, 16'h0002, 8'h00));
		send_item(build_item(KIND_START, 8'hFF, 16'hFFFF, 8'hFF));
		send_item(build_item(KIND_START, 8'h00, 16'h0000, 8'h00));
		send_item(build_item(KIND_PAYLOAD, 8'h00, 16'h0000, 8'hFF));
		send_item(build_item(KIND_PAYLOAD, 8'hFF, 16'hFFFF, 8'h81));
		send_item(build_item(KIND_START, 8'h12, 16'(LONGEST_PAYLOAD + 1), 8'h00));
		send_item(build_item(KIND_START, 8'h00, 16'hFFFF, 8'h00));
		send_item(build_item(KIND_PAYLOAD, 8'h00, 16'h0000, 8'h00));
		load_frame_bytes(8'h00, 8'h00, 8'h00, 8'h00);
		send_item(build_item(KIND_START, 8'hC3, 16'h0003, 8'h00));
		send_frame(0, 1'b0);
		settle();
	endtask

	task automatic test_register_sweep();
		load_frame_bytes(8'hAA, 8'h55, 8'h0F, 8'hF0);
		send_frame(pick_length(), 1'b0);
		for (int s = 0; s < 5; s++) begin
			load_frame_bytes(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
			send_frame(pick_length(), 1'b0);
			send_frame(pick_length(), 1'b0);
		end
		settle();
	endtask

	task automatic test_random_traffic();
		int stop_at;
		int pick;
		stop_at = items_sent + RANDOM_ITEMS;
		while (items_sent < stop_at) begin
			send_gaps_on   = $urandom_range(0, 3) != 0;
			recv_stalls_on = $urandom_range(0, 3) != 0;
			pick = $urandom_range(0, 99);
			if (pick < 6) begin
				load_frame_bytes(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
			end else if (pick < 14) begin
				send_item(make_item(KIND_PAYLOAD));
			end else if (pick < 20) begin
				send_frame($urandom_range(LONGEST_PAYLOAD + 1, 16'hFFFF), 1'b0);
			end else begin
				send_frame(pick_length(), pick < 40);
			end
		end
		settle();
	endtask

	task automatic test_output_backpressure();
		send_gaps_on   = 1'b0;
		recv_stalls_on = 1'b1;
		hold_request   = 200;
		for (int f = 0; f < 4; f++) begin
			send_frame($urandom_range(4, 12), 1'b0);
		end
		settle();
	endtask

	task automatic test_sender_pause();
		send_gaps_on   = 1'b1;
		recv_stalls_on = 1'b1;
		send_item(build_item(KIND_START, 8'($urandom), 16'd6, 8'($urandom)));
		repeat (3) send_item(make_item(KIND_PAYLOAD));
		settle();
		repeat (3) send_item(make_item(KIND_PAYLOAD));
		settle();
	endtask

	task automatic test_longest_frame();
		load_frame_bytes(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
		send_gaps_on   = 1'b0;
		recv_stalls_on = 1'b0;
		while (frame_is_open) begin
			send_item(make_item(KIND_PAYLOAD));
		end
		send_item(build_item(KIND_START, 8'($urandom), 16'(LONGEST_PAYLOAD), 8'($urandom)));
		repeat (8) send_item(make_item(KIND_PAYLOAD));
		send_item(build_item(KIND_START, 8'($urandom), 16'd0, 8'($urandom)));
		settle();
	endtask

	initial begin
		for (int i = 0; i < 4; i++) begin
			frame_cfg[i] = 8'h00;
		end
		frame_is_open = 1'b0;
		bytes_left    = '0;
		running_chk   = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_values();
		test_special_cases();
		test_register_sweep();
		test_output_backpressure();
		test_sender_pause();
		test_random_traffic();
		test_longest_frame();

		settle();
		repeat (20) @(posedge clk);
		$display("run: %0d items, %0d beats checked, %0d frames closed, %0d error beats",
			items_sent, beats_checked, frames_closed, error_beats);
		$display("input held off by full: %s, frame opened at the top legal length of %0d",
			saw_full ? "yes" : "no", LONGEST_PAYLOAD);
		if (fail_count == 0 && pending_beats.size() == 0) begin
			$display("length_type_xor_frame_builder verification clean");
		end else begin
			$display("length_type_xor_frame_builder verification failed");
		end
		$finish;
	end

endmodule
